// ===== hdl/smv_pkg.sv =====
// Shared types and constants for the sparse matrix-vector multiply block.
// No dependencies; imported by the top level, smv_mult and smv_acc.
package smv_pkg;

  // Fixed field widths of the request and result channels and of the accumulator
  localparam int COLUMN_WIDTH = 10;
  localparam int ROW_WIDTH    = 10;
  localparam int OUT_WIDTH    = 32;
  localparam int ACC_WIDTH    = 64;

  // Defaults for the top level parameters
  localparam int DEFAULT_VECTOR_DEPTH = 1024;
  localparam int DEFAULT_VALUE_WIDTH  = 32;

  // Operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_ENTRY = 2'd1;
  localparam logic [1:0] OP_EMPTY = 2'd2;
  localparam logic [1:0] OP_IDLE  = 2'd3;

  // Control that travels with a request down the pipeline
  typedef struct packed {
    logic [1:0] op;
    logic       last;
  } ctrl_t;

endpackage

// ===== hdl/sparse_matrix_vector_multiply.sv =====
// Sparse matrix-vector multiply (row-compressed stream), y = A*x.
// Throughput: one request per cycle while the output is not stalled; the vector RAM is read once per in-range entry.
// A row result appears on out_valid once the request that closes the row has passed
// the RAM read, multiply, round, accumulate and output registers.
// Reset clears the pipeline, the row sum and the row count; the vector RAM is
// not cleared and an element holds no defined value until it is loaded.
module sparse_matrix_vector_multiply
  import smv_pkg::*;
#(
  parameter int VECTOR_DEPTH = DEFAULT_VECTOR_DEPTH,
  parameter int VALUE_WIDTH  = DEFAULT_VALUE_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              operation,
  input  logic [COLUMN_WIDTH-1:0] column,
  input  logic [OUT_WIDTH-1:0]    operand_value,
  input  logic                    last_in_row,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ROW_WIDTH-1:0]    row_index,
  output logic [OUT_WIDTH-1:0]    product_value,
  output logic                    saturated
);

  localparam int ADDR_WIDTH = $clog2(VECTOR_DEPTH);

  logic                          accept;
  logic                          in_range;
  logic                          ram_en;
  logic [VALUE_WIDTH-1:0]        ram_rdata;
  logic                          v1;
  ctrl_t                         ctl1;
  logic signed [VALUE_WIDTH-1:0] a1;
  logic                          range1;
  logic                          mult_ready;
  logic                          mult_valid;
  ctrl_t                         mult_ctrl;
  logic signed [ACC_WIDTH-1:0]   mult_rounded;
  logic                          acc_ready;
  logic                          en_1;

  assign en_1     = !v1 || mult_ready;
  assign in_ready = en_1;
  assign accept   = in_valid && in_ready;
  assign in_range = int'(column) < VECTOR_DEPTH;

  // Loads write the store, entries read it; nothing else touches it
  assign ram_en = accept && in_range &&
                  (operation == OP_LOAD || operation == OP_ENTRY);

  smv_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(VECTOR_DEPTH)
  ) u_vec_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (operation == OP_LOAD),
    .addr (ADDR_WIDTH'(column)),
    .wdata(operand_value[VALUE_WIDTH-1:0]),
    .rdata(ram_rdata)
  );

  // Request stage, aligned with the RAM read data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en_1) begin
      v1 <= accept && (operation != OP_IDLE);
    end
    if (accept) begin
      ctl1.op   <= operation;
      ctl1.last <= last_in_row;
      a1        <= operand_value[VALUE_WIDTH-1:0];
      range1    <= in_range;
    end
  end

  smv_mult #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_mult (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v1),
    .in_ready (mult_ready),
    .ctrl_in  (ctl1),
    .a        (a1),
    .x        (ram_rdata),
    .in_range (range1),
    .out_valid(mult_valid),
    .out_ready(acc_ready),
    .ctrl_out (mult_ctrl),
    .rounded  (mult_rounded)
  );

  smv_acc #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_acc (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (mult_valid),
    .in_ready     (acc_ready),
    .ctrl_in      (mult_ctrl),
    .rounded      (mult_rounded),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .row_index    (row_index),
    .product_value(product_value),
    .saturated    (saturated)
  );

  // Saturation limits as seen on the output port
  localparam logic [OUT_WIDTH-1:0] OUT_HI =
    OUT_WIDTH'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
  localparam logic [OUT_WIDTH-1:0] OUT_LO = ~OUT_HI;

  // With nothing waiting at the output, the whole pipeline can move
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // A request that does work enters the pipeline
  a_request_enters: assert property (@(posedge clk) disable iff (rst)
    (accept && operation != OP_IDLE) |=> v1)
    else $error("accepted request lost at entry");

  // A saturated result sits at one of the range limits
  a_sat_limits: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (product_value == OUT_HI || product_value == OUT_LO))
    else $error("saturated result not at a range limit");

endmodule

// ===== hdl/smv_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module smv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, or read into the registered read data
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== hdl/smv_mult.sv =====
// Multiply and round pipeline: entry value times vector element, rounded
// back to the value format and sign-extended to the accumulator width. Uses smv_pkg.
module smv_mult
  import smv_pkg::*;
#(
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ctrl_t                         ctrl_in,
  input  logic signed [VALUE_WIDTH-1:0] a,
  input  logic signed [VALUE_WIDTH-1:0] x,
  input  logic                          in_range,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ctrl_t                         ctrl_out,
  output logic signed [ACC_WIDTH-1:0]   rounded
);

  localparam int FRAC_BITS = VALUE_WIDTH / 2;
  localparam logic signed [ACC_WIDTH-1:0] ROUND_BIAS =
    ACC_WIDTH'(64'd1 << (FRAC_BITS - 1));

  logic                            vp;
  ctrl_t                           pctl;
  logic signed [2*VALUE_WIDTH-1:0] prod;
  logic signed [VALUE_WIDTH-1:0]   xv;
  logic signed [ACC_WIDTH-1:0]     prod_ext;
  logic signed [ACC_WIDTH-1:0]     biased;
  logic                            en_p;
  logic                            en_r;

  // Stage enables: a stage moves when it is empty or its successor moves
  assign en_r     = !out_valid || out_ready;
  assign en_p     = !vp || en_r;
  assign in_ready = en_p;

  // Column beyond the store multiplies by zero
  assign xv = in_range ? x : '0;

  // Round half up to the value format
  assign prod_ext = ACC_WIDTH'(prod);
  assign biased   = prod_ext + ROUND_BIAS;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_p) begin
        vp <= in_valid;
      end
      if (en_r) begin
        out_valid <= vp;
      end
    end
  end

  // Product stage, then rounding stage
  always_ff @(posedge clk) begin
    if (en_p && in_valid) begin
      pctl <= ctrl_in;
      prod <= a * xv;
    end
    if (en_r && vp) begin
      ctrl_out <= pctl;
      rounded  <= biased >>> FRAC_BITS;
    end
  end

endmodule

// ===== hdl/smv_acc.sv =====
// Row accumulator, row counter, saturation and output register.
// Uses smv_pkg.
module smv_acc
  import smv_pkg::*;
#(
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ctrl_t                       ctrl_in,
  input  logic signed [ACC_WIDTH-1:0] rounded,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ROW_WIDTH-1:0]        row_index,
  output logic [OUT_WIDTH-1:0]        product_value,
  output logic                        saturated
);

  localparam logic signed [VALUE_WIDTH-1:0] SAT_HI =
    VALUE_WIDTH'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
  localparam logic signed [VALUE_WIDTH-1:0] SAT_LO = ~SAT_HI;

  logic [ACC_WIDTH-1:0]          row_sum;
  logic [ROW_WIDTH-1:0]          current_row;
  logic                          va;
  logic [ACC_WIDTH-1:0]          asum;
  logic [ROW_WIDTH-1:0]          arow;
  logic [ACC_WIDTH-1:0]          sum_add;
  logic                          sat;
  logic signed [VALUE_WIDTH-1:0] sat_val;
  logic                          en_a;
  logic                          en_o;

  assign en_o     = !out_valid || out_ready;
  assign en_a     = !va || en_o;
  assign in_ready = en_a;

  assign sum_add = row_sum + rounded;

  // Sum fits when all bits from the sign of the value range up agree
  assign sat     = !((&asum[ACC_WIDTH-1:VALUE_WIDTH-1]) ||
                     !(|asum[ACC_WIDTH-1:VALUE_WIDTH-1]));
  assign sat_val = sat ? (asum[ACC_WIDTH-1] ? SAT_LO : SAT_HI)
                       : asum[VALUE_WIDTH-1:0];

  // Accumulate, close rows; a load clears the row sum and the row count
  always_ff @(posedge clk) begin
    if (rst) begin
      va          <= 1'b0;
      row_sum     <= '0;
      current_row <= '0;
    end else if (en_a) begin
      va <= 1'b0;
      if (in_valid) begin
        unique case (ctrl_in.op)
          OP_LOAD: begin
            row_sum     <= '0;
            current_row <= '0;
          end
          OP_ENTRY: begin
            if (ctrl_in.last) begin
              va          <= 1'b1;
              asum        <= sum_add;
              arow        <= current_row;
              row_sum     <= '0;
              current_row <= current_row + 1'b1;
            end else begin
              row_sum <= sum_add;
            end
          end
          OP_EMPTY: begin
            va          <= 1'b1;
            asum        <= row_sum;
            arow        <= current_row;
            row_sum     <= '0;
            current_row <= current_row + 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Output register with saturation
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_o) begin
      out_valid <= va;
    end
    if (en_o && va) begin
      row_index     <= arow;
      product_value <= OUT_WIDTH'(sat_val);
      saturated     <= sat;
    end
  end

endmodule
